// ===== rtl/core/timed_position_history_interp_core_defines.svh =====
// Assertion macros for the position history core.
`ifndef TIMED_POSITION_HISTORY_INTERP_CORE_DEFINES_SVH
`define TIMED_POSITION_HISTORY_INTERP_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TPH_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TPH_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define TPH_ASSERT(label, clk, rstn, prop, msg)
`define TPH_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

// ===== rtl/core/tphi_pkg.sv =====
// ----------------------------------------------------------------------------
// tphi_pkg
// Shared types and constants of the position history core.
// ----------------------------------------------------------------------------
`default_nettype none
package tphi_pkg;
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [1:0] OpRecord = 2'd0;
  localparam logic [1:0] OpRead   = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;

  localparam logic [2:0] StStored  = 3'd0;
  localparam logic [2:0] StSkipped = 3'd1;
  localparam logic [2:0] StRead    = 3'd2;
  localparam logic [2:0] StEmpty   = 3'd3;
  localparam logic [2:0] StCleared = 3'd4;

  localparam logic [1:0] CfgInterval = 2'd0;
  localparam logic [1:0] CfgLength   = 2'd1;
  localparam logic [1:0] CfgAlways   = 2'd2;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } entry_t;

  // per-cell control broadcast from the controller
  typedef struct packed {
    logic push;   // shift a new entry in at cell 0
    logic rot;    // rotate the ring by one cell
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/tphi_if.sv =====
// ----------------------------------------------------------------------------
// tphi_in_if / tphi_out_if / tphi_cfg_if
// Valid/ready channels of the position history core.
// ----------------------------------------------------------------------------
`default_nettype none
interface tphi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] time_ms;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, op, time_ms, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, op, time_ms, pos_x, pos_y, pos_z, output ready);
endinterface

interface tphi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  modport source (output valid, status, out_x, out_y, out_z, input ready);
  modport sink   (input valid, status, out_x, out_y, out_z, output ready);
endinterface

interface tphi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tphi_cell.sv =====
// ----------------------------------------------------------------------------
// tphi_cell
// One history slot. Cells form a ring; cell 0 sees the newest entry once
// the ring is rotated into place, and takes new entries on a push.
// ----------------------------------------------------------------------------
`default_nettype none
module tphi_cell (
  input  wire logic              clk_i,
  input  wire tphi_pkg::cell_ctl_t ctl_i,
  input  wire tphi_pkg::entry_t  new_i,
  input  wire tphi_pkg::entry_t  prev_i,
  output tphi_pkg::entry_t       ent_o
);
  tphi_pkg::entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.push) ent_d = new_i;
    else if (ctl_i.rot) ent_d = prev_i;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
endmodule
`default_nettype wire

// ===== rtl/core/tphi_divider.sv =====
// ----------------------------------------------------------------------------
// tphi_divider
// Restoring divider: floor(num * 65536 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tphi_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [15:0]      quo_o
);
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [15:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, 1'b0} - {2'b00, den_q};
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], 1'b0};
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/timed_position_history_interp_core.sv =====
// Flow: clear is answered from idle; record rotates the ring until the newest
// entry is back at cell 0, then makes the store decision; read aligns alike,
// then, if the time lies between entries, walks, divides, multiplies, sums.
// One item at a time; input is ready in the cycle after the result beat is taken.
// Reset: history empty, registers to write_interval 100, length 16, off.
// ----------------------------------------------------------------------------
// timed_position_history_interp_core
// Ring of timestamped positions with linear interpolation on read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_position_history_interp_core_defines.svh"
module timed_position_history_interp_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tphi_cfg_if.sink    cfg_i,
  tphi_in_if.sink     in_i,
  tphi_out_if.source  out_o
);
  localparam int unsigned D = tphi_pkg::Depth;
  localparam int unsigned IW = tphi_pkg::IdxW;
  localparam int unsigned CW = tphi_pkg::CntW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;  // rotate newest into cell 0
  localparam logic [2:0] S_WALK  = 3'd2;  // read search, newest downward
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;

  // Ring invariant: cell k holds the entry that is k steps older than the
  // one at cell 0 (entry at cell 0 is the newest when aligned).
  // rot_q counts rotations since cell 0 last held the newest.
  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] rot_q, rot_d;     // cells rotated since newest was at cell 0
  logic [15:0]   wint_q;
  logic [CW-1:0] hlen_q;
  logic          alw_q;

  logic [1:0]  op_q;
  logic [31:0] t_q;
  logic [31:0] px_q, py_q, pz_q;

  logic        ov_q, ov_d;
  logic [2:0]  ost_q, ost_d;
  logic [31:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;

  tphi_pkg::entry_t  ents [D];
  tphi_pkg::entry_t  new_ent;
  tphi_pkg::cell_ctl_t ctl;

  logic [CW-1:0] lim;
  logic [IW-1:0] step_q, step_d;
  tphi_pkg::entry_t a_q, b_q, a_d, b_d;
  logic div_start, div_done;
  logic [15:0] quo;
  logic [31:0] num, den;
  logic signed [48:0] pax_q, pbx_q, pay_q, pby_q, paz_q, pbz_q;
  logic signed [49:0] sx, sy, sz;
  logic [16:0] pinv;
  logic [15:0] p_q, p_d;

  // ring: cell k takes from cell k+1 on rotate, so cell 0 gets older entry
  // rotation brings next-older into cell 0; last wraps from cell 0.
  genvar g;
  for (g = 0; g < D; g++) begin : g_cell
    if (g == D - 1) begin : g_last
      tphi_cell u_cell (.clk_i(clk_i), .ctl_i(ctl), .new_i(ents[g - 1]),
                        .prev_i(ents[0]), .ent_o(ents[g]));
    end else if (g == 0) begin : g_first
      tphi_cell u_cell (.clk_i(clk_i), .ctl_i(ctl), .new_i(new_ent),
                        .prev_i(ents[1]), .ent_o(ents[g]));
    end else begin : g_mid
      tphi_cell u_cell (.clk_i(clk_i), .ctl_i(ctl), .new_i(ents[g - 1]),
                        .prev_i(ents[g + 1]), .ent_o(ents[g]));
    end
  end

  assign new_ent = '{t: t_q, x: px_q, y: py_q, z: pz_q};

  always_comb begin
    if (hlen_q == '0) lim = CW'(1);
    else if (hlen_q > CW'(D)) lim = CW'(D);
    else lim = hlen_q;
  end

  assign num = t_q - a_q.t;
  assign den = b_q.t - a_q.t;
  assign pinv = 17'd65536 - {1'b0, p_q};
  assign sx = 50'(pax_q) + 50'(pbx_q);
  assign sy = 50'(pay_q) + 50'(pby_q);
  assign sz = 50'(paz_q) + 50'(pbz_q);

  tphi_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(num), .den_i(den), .done_o(div_done), .quo_o(quo)
  );

  assign in_i.ready  = (st_q == S_IDLE) && !ov_q;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid  = ov_q;
  assign out_o.status = ost_q;
  assign out_o.out_x  = ox_q;
  assign out_o.out_y  = oy_q;
  assign out_o.out_z  = oz_q;

  logic [IW-1:0] old_idx;
  assign old_idx = IW'(cnt_q - CW'(1));

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rot_d = rot_q; step_d = step_q;
    ov_d = ov_q; ost_d = ost_q; ox_d = ox_q; oy_d = oy_q; oz_d = oz_q;
    a_d = a_q; b_d = b_q; p_d = p_q;
    ctl = '{push: 1'b0, rot: 1'b0};
    div_start = 1'b0;
    if (ov_q && out_o.ready) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          case (in_i.op)
            tphi_pkg::OpRecord, tphi_pkg::OpRead: st_d = S_ALIGN;
            tphi_pkg::OpClear: begin
              cnt_d = '0; rot_d = '0;
              ov_d = 1'b1; ost_d = tphi_pkg::StCleared;
              ox_d = '0; oy_d = '0; oz_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_ALIGN: begin
        if (rot_q != '0) begin
          // keep rotating until the ring has come full circle
          ctl.rot = 1'b1;
          rot_d = rot_q + IW'(1);
        end else if (op_q == tphi_pkg::OpRecord) begin
          ox_d = '0; oy_d = '0; oz_d = '0; ov_d = 1'b1;
          if (cnt_q == '0 || alw_q ||
              (t_q - ents[0].t) >= {16'd0, wint_q}) begin
            ctl.push = 1'b1;
            cnt_d = (cnt_q + CW'(1) > lim) ? lim : cnt_q + CW'(1);
            ost_d = tphi_pkg::StStored;
          end else begin
            ost_d = tphi_pkg::StSkipped;
          end
          st_d = S_IDLE;
        end else begin
          ox_d = '0; oy_d = '0; oz_d = '0;
          if (cnt_q == '0) begin
            ov_d = 1'b1; ost_d = tphi_pkg::StEmpty; st_d = S_IDLE;
          end else if (t_q <= ents[old_idx].t) begin
            ov_d = 1'b1; ost_d = tphi_pkg::StRead; st_d = S_IDLE;
            ox_d = ents[old_idx].x; oy_d = ents[old_idx].y;
            oz_d = ents[old_idx].z;
          end else if (t_q >= ents[0].t) begin
            ov_d = 1'b1; ost_d = tphi_pkg::StRead; st_d = S_IDLE;
            ox_d = ents[0].x; oy_d = ents[0].y; oz_d = ents[0].z;
          end else begin
            step_d = '0; st_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        // cell 0 is newer candidate, cell 1 older; advance while t < older and the oldest pair is not yet reached
        if (t_q < ents[1].t && step_q != IW'(cnt_q - CW'(2))) begin
          ctl.rot = 1'b1;
          rot_d = rot_q + IW'(1);
          step_d = step_q + IW'(1);
        end else begin
          a_d = ents[1]; b_d = ents[0];
          st_d = S_DIV;
        end
      end
      S_DIV: begin
        // on entry start the divider, then wait for its done pulse
        if (step_q != '1) begin
          div_start = 1'b1;
          step_d = '1;
        end else if (div_done) begin
          p_d = (den == '0) ? 16'd0 : quo;
          st_d = S_MUL;
        end
      end
      S_MUL: st_d = S_SUM;
      S_SUM: begin
        ox_d = sx[47:16]; oy_d = sy[47:16]; oz_d = sz[47:16];
        ov_d = 1'b1; ost_d = tphi_pkg::StRead; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; rot_q <= '0; ov_q <= 1'b0;
      wint_q <= 16'd100; hlen_q <= CW'(D); alw_q <= 1'b0; step_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d; rot_q <= rot_d; ov_q <= ov_d; step_q <= step_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          tphi_pkg::CfgInterval: wint_q <= cfg_i.data;
          tphi_pkg::CfgLength:   hlen_q <= CW'(cfg_i.data[4:0]);
          tphi_pkg::CfgAlways:   alw_q <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ost_q <= ost_d; ox_q <= ox_d; oy_q <= oy_d; oz_q <= oz_d;
    a_q <= a_d; b_q <= b_d; p_q <= p_d;
    if (in_i.valid && in_i.ready) begin
      op_q <= in_i.op; t_q <= in_i.time_ms;
      px_q <= in_i.pos_x; py_q <= in_i.pos_y; pz_q <= in_i.pos_z;
    end
    pax_q <= $signed({1'b0, pinv}) * $signed(a_q.x);
    pbx_q <= $signed({1'b0, p_q}) * $signed(b_q.x);
    pay_q <= $signed({1'b0, pinv}) * $signed(a_q.y);
    pby_q <= $signed({1'b0, p_q}) * $signed(b_q.y);
    paz_q <= $signed({1'b0, pinv}) * $signed(a_q.z);
    pbz_q <= $signed({1'b0, p_q}) * $signed(b_q.z);
  end

  `TPH_ASSERT(a_cnt_le_depth, clk_i, rst_ni, cnt_q <= CW'(D), "count above depth")
  `TPH_ASSERT(a_busy_no_accept, clk_i, rst_ni, !(in_i.ready && st_q != S_IDLE), "ready while busy")
  `TPH_ASSERT_NEXT(a_div_walk, clk_i, rst_ni, st_q == S_WALK && st_d == S_DIV, a_q.t < b_q.t, "bracket not ordered")
endmodule
`default_nettype wire
